[rtl/cbsm_pkg.sv]
package cbsm_pkg;

  localparam logic [1:0] CMD_WRITE   = 2'd0;
  localparam logic [1:0] CMD_PROGRAM = 2'd1;
  localparam logic [1:0] CMD_PICTURE = 2'd2;

  localparam logic [15:0] REG_ADDR_MASK = 16'hE001;
  localparam logic [15:0] REG_SELECT    = 16'h8000;
  localparam logic [15:0] REG_BANK_DATA = 16'h8001;

  // bank-select codes
  localparam logic [7:0] SEL_CHR_PAIR_0 = 8'h00;
  localparam logic [7:0] SEL_CHR_PAIR_2 = 8'h01;
  localparam logic [7:0] SEL_CHR_4      = 8'h02;
  localparam logic [7:0] SEL_CHR_5      = 8'h03;
  localparam logic [7:0] SEL_CHR_6      = 8'h04;
  localparam logic [7:0] SEL_CHR_7      = 8'h05;
  localparam logic [7:0] SEL_PRG_0      = 8'h06;
  localparam logic [7:0] SEL_PRG_1      = 8'h07;
  localparam logic [7:0] SEL_PRG_2      = 8'h46;
  localparam logic [7:0] SEL_PRG_1_ALT  = 8'h47;
  localparam logic [7:0] SEL_CHR_PAIR_4 = 8'h80;
  localparam logic [7:0] SEL_CHR_PAIR_6 = 8'h81;
  localparam logic [7:0] SEL_CHR_0      = 8'h82;
  localparam logic [7:0] SEL_CHR_1      = 8'h83;
  localparam logic [7:0] SEL_CHR_2      = 8'h84;
  localparam logic [7:0] SEL_CHR_3      = 8'h85;

  localparam logic [3:0][7:0] PRG_BANK_RESET = {8'hFF, 8'hFE, 8'h01, 8'h00};
  localparam logic [7:0][7:0] CHR_BANK_RESET =
    {8'd7, 8'd6, 8'd5, 8'd4, 8'd3, 8'd2, 8'd1, 8'd0};

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] address;
    logic [7:0]  data;
  } req_t;

  typedef struct packed {
    logic [20:0] rom_address;
    logic        hit;
    logic        forwarded;
  } rsp_t;

endpackage

[rtl/cbsm_stream_if.sv]
interface cbsm_stream_if #(
  parameter type payload_t = logic [7:0]
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[rtl/cartridge_bank_switch_mapper.sv]
// Bank-switch mapper with an MMC3-style register interface.
// req channel (cbsm_pkg::req_t): cmd selects a processor write, a program
//   address translation or a picture address translation.
// rsp channel (cbsm_pkg::rsp_t): exactly one transaction per request, in order,
//   carrying the ROM byte address, hit and forwarded flags.
// Pipeline: a request is loaded into the input register, then into the
//   result register once that is free, and is presented on rsp from there.
// Throughput: one transaction per cycle while rsp keeps taking results; the
//   bank registers are read and written in the same cycle the request leaves
//   the input register, so a write is seen by the very next request.
// Reset (rst, synchronous): bank select clears, program banks go to
//   0, 1, 0xFE, 0xFF, picture banks to 0..7, both stages empty.
// Stall: when rsp is not taken the result register holds; the input
//   register keeps accepting until it too is full, then req.ready drops.
module cartridge_bank_switch_mapper #(
  parameter int PROGRAM_BANK_COUNT = 256,
  parameter int PICTURE_BANK_COUNT = 256
) (
  input  logic          clk,
  input  logic          rst,
  cbsm_stream_if.sink   req,
  cbsm_stream_if.source rsp
);
  import cbsm_pkg::*;

  localparam logic [8:0] PRG_COUNT = 9'(PROGRAM_BANK_COUNT);
  localparam logic [8:0] CHR_COUNT = 9'(PICTURE_BANK_COUNT);
  localparam logic [7:0] PRG_MASK  = 8'(PROGRAM_BANK_COUNT - 1);
  localparam logic [7:0] CHR_MASK  = 8'(PICTURE_BANK_COUNT - 1);

  logic            in_valid;
  req_t            in_req;
  logic            out_valid;
  rsp_t            out_rsp;
  rsp_t            out_rsp_next;
  logic            out_free;
  logic            advance;
  logic [15:0]     reg_sel;
  logic [7:0]      bank_select;
  logic [3:0][7:0] program_banks;
  logic [7:0][7:0] picture_banks;
  logic [7:0]      prg_raw;
  logic [7:0]      chr_raw;
  logic [7:0]      prg_bank;
  logic [7:0]      chr_bank;

  assign out_free  = !out_valid || rsp.ready;
  assign advance   = in_valid && out_free;
  assign req.ready = !in_valid || out_free;
  assign rsp.valid = out_valid;
  assign rsp.payload = out_rsp;

  assign reg_sel = in_req.address & REG_ADDR_MASK;
  assign prg_raw = program_banks[in_req.address[14:13]];
  assign chr_raw = picture_banks[in_req.address[12:10]];
  assign prg_bank = ({1'b0, prg_raw} >= PRG_COUNT) ? (prg_raw & PRG_MASK) : prg_raw;
  assign chr_bank = ({1'b0, chr_raw} >= CHR_COUNT) ? (chr_raw & CHR_MASK) : chr_raw;

  always_comb begin
    out_rsp_next = '0;
    case (in_req.cmd)
      CMD_WRITE: begin
        if (reg_sel == REG_SELECT || reg_sel == REG_BANK_DATA) begin
          out_rsp_next.hit = 1'b1;
        end else begin
          out_rsp_next.forwarded = 1'b1;
        end
      end
      CMD_PROGRAM: begin
        if (in_req.address[15]) begin
          out_rsp_next.rom_address = {prg_bank, in_req.address[12:0]};
          out_rsp_next.hit = 1'b1;
        end
      end
      CMD_PICTURE: begin
        if (in_req.address[15:13] == 3'd0) begin
          out_rsp_next.rom_address = {3'd0, chr_bank, in_req.address[9:0]};
          out_rsp_next.hit = 1'b1;
        end
      end
      default: out_rsp_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (req.valid && req.ready) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_req <= req.payload;
    end
    if (advance) begin
      out_rsp <= out_rsp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bank_select   <= '0;
      program_banks <= PRG_BANK_RESET;
      picture_banks <= CHR_BANK_RESET;
    end else if (advance && in_req.cmd == CMD_WRITE) begin
      if (reg_sel == REG_SELECT) begin
        bank_select <= in_req.data;
      end else if (reg_sel == REG_BANK_DATA) begin
        case (bank_select)
          SEL_CHR_PAIR_0: begin
            picture_banks[0] <= {in_req.data[7:1], 1'b0};
            picture_banks[1] <= {in_req.data[7:1], 1'b1};
          end
          SEL_CHR_PAIR_2: begin
            picture_banks[2] <= {in_req.data[7:1], 1'b0};
            picture_banks[3] <= {in_req.data[7:1], 1'b1};
          end
          SEL_CHR_4:     picture_banks[4] <= in_req.data;
          SEL_CHR_5:     picture_banks[5] <= in_req.data;
          SEL_CHR_6:     picture_banks[6] <= in_req.data;
          SEL_CHR_7:     picture_banks[7] <= in_req.data;
          SEL_PRG_0:     program_banks[0] <= in_req.data;
          SEL_PRG_1:     program_banks[1] <= in_req.data;
          SEL_PRG_2:     program_banks[2] <= in_req.data;
          SEL_PRG_1_ALT: program_banks[1] <= in_req.data;
          SEL_CHR_PAIR_4: begin
            picture_banks[4] <= {in_req.data[7:1], 1'b0};
            picture_banks[5] <= {in_req.data[7:1], 1'b1};
          end
          SEL_CHR_PAIR_6: begin
            picture_banks[6] <= {in_req.data[7:1], 1'b0};
            picture_banks[7] <= {in_req.data[7:1], 1'b1};
          end
          SEL_CHR_0:     picture_banks[0] <= in_req.data;
          SEL_CHR_1:     picture_banks[1] <= in_req.data;
          SEL_CHR_2:     picture_banks[2] <= in_req.data;
          SEL_CHR_3:     picture_banks[3] <= in_req.data;
          default: ;
        endcase
      end
    end
  end

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_rsp.hit && out_rsp.forwarded))
    else $error("hit and forwarded both set");

  a_fwd_no_address: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_rsp.forwarded |-> out_rsp.rom_address == '0)
    else $error("forwarded transaction carries a ROM address");

  a_advance_fills_out: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("result register lost a transaction");

  a_read_keeps_banks: assert property (@(posedge clk) disable iff (rst)
    advance && in_req.cmd != CMD_WRITE |=>
      $stable(program_banks) && $stable(picture_banks) && $stable(bank_select))
    else $error("translation changed bank state");

  a_select_keeps_banks: assert property (@(posedge clk) disable iff (rst)
    advance && in_req.cmd == CMD_WRITE && reg_sel == REG_SELECT |=>
      $stable(program_banks) && $stable(picture_banks))
    else $error("bank-select write changed a bank register");

endmodule
